// ===== rtl/dtvs_pkg.sv =====
// Shared types and constants for the dirty tracked value store.
// Used by the controller, the datapath and the top level.
package dtvs_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = 6;
  localparam int LIM_W   = 7;

  localparam logic [LIM_W-1:0] ENTRIES_LIM = LIM_W'(ENTRIES);
  localparam logic [LIM_W-1:0] CFG_RESET   = 7'd64;

  localparam logic [3:0] CMD_WRITE   = 4'd0;
  localparam logic [3:0] CMD_CLAMP   = 4'd1;
  localparam logic [3:0] CMD_BYTE    = 4'd2;
  localparam logic [3:0] CMD_HALF    = 4'd3;
  localparam logic [3:0] CMD_SET     = 4'd4;
  localparam logic [3:0] CMD_CLEAR   = 4'd5;
  localparam logic [3:0] CMD_WIDE    = 4'd6;
  localparam logic [3:0] CMD_READ    = 4'd7;
  localparam logic [3:0] CMD_UNMARK  = 4'd8;
  localparam logic [3:0] CMD_LOAD    = 4'd9;

  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the input item and read its first word
    logic wide_lo;     // compare low word, read the second word
    logic wide_cmp;    // compare high word, write the low word
    logic fin_single;  // finish a one-word command and load the result
    logic fin_wide;    // write the high word and load the result
  } dtvs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_wide;     // held item is an in-range 64-bit write
    logic out_free;    // result register can take a new result
  } dtvs_stat_t;

endpackage

// ===== rtl/dirty_tracked_value_store.sv =====
// Top level of the dirty tracked value store: controller plus datapath.
// Depends on dtvs_pkg, dtvs_ctrl and dtvs_datapath.
//
//   channel   direction  content
//   s_axis    in         tuser: command; tdata: index, lane, value
//   m_axis    out        tdata: read_value, changed, dirty, error
//   cfg       in         cfg_we, cfg_data: values_in_use
//
// On acceptance the addressed word is read from the single-port word memory;
// the result is then computed, written and loaded into the result register.
// A 64-bit write takes extra steps, since its two words share the one memory port.
// Synchronous reset clears all words (through per-word valid bits) and dirty marks
// at once; no clearing pass. A stalled output holds the block only at the point
// where the next result would be loaded; a new item is accepted while one waits.
module dirty_tracked_value_store
  import dtvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: index[5:0], lane[7:6], value[71:8]
  input  logic [71:0] s_axis_tdata,
  // tuser fields from bit 0: command[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: read_value[31:0], changed[32], dirty[33], error[34],
  // zero padding[39:35]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  dtvs_cmd_t   cmd;
  dtvs_stat_t  stat;
  logic [31:0] read_value;
  logic        changed;
  logic        dirty;
  logic        error;

  dtvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtvs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_command     (s_axis_tuser),
    .in_index       (s_axis_tdata[5:0]),
    .in_lane        (s_axis_tdata[7:6]),
    .in_value       (s_axis_tdata[71:8]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_read_value (read_value),
    .out_changed    (changed),
    .out_dirty      (dirty),
    .out_error      (error)
  );

  assign m_axis_tdata = {5'd0, error, dirty, changed, read_value};

  // Once an item is taken, the input is not ready in the cycle after the transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again in the cycle after a transfer");

  // A result is only loaded when the result register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_single || cmd.fin_wide) |-> stat.out_free)
    else $error("result loaded over a pending transfer");

  // The controller issues at most one step per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.wide_lo, cmd.wide_cmp, cmd.fin_single, cmd.fin_wide}))
    else $error("more than one controller step at once");

  // The high-word compare always follows the low-word compare.
  a_wide_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wide_lo |=> cmd.wide_cmp)
    else $error("64-bit write sequence broken");

endmodule

// ===== rtl/dtvs_ctrl.sv =====
// Sequencing state machine for the dirty tracked value store.
// Depends on dtvs_pkg for the command and status structs.
module dtvs_ctrl
  import dtvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dtvs_stat_t stat,
  output dtvs_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WCMP = 2'd2;
  localparam logic [1:0] S_WFIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_wide) begin
          cmd.wide_lo = 1'b1;
          state_next  = S_WCMP;
        end else if (stat.out_free) begin
          cmd.fin_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_WCMP: begin
        cmd.wide_cmp = 1'b1;
        state_next   = S_WFIN;
      end
      S_WFIN: begin
        if (stat.out_free) begin
          cmd.fin_wide = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dtvs_datapath.sv =====
// Word memory, dirty marks, limit register and result register.
// Depends on dtvs_pkg; driven by commands from dtvs_ctrl.
module dtvs_datapath
  import dtvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dtvs_cmd_t        cmd,
  output dtvs_stat_t       stat,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_data,
  input  logic [3:0]       in_command,
  input  logic [IDX_W-1:0] in_index,
  input  logic [1:0]       in_lane,
  input  logic [63:0]      in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_read_value,
  output logic             out_changed,
  output logic             out_dirty,
  output logic             out_error
);

  logic [31:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [ENTRIES-1:0] marks;
  logic [LIM_W-1:0] values_in_use;

  logic [3:0]       cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       lane_q;
  logic [63:0]      val_q;
  logic [31:0]      rdata;
  logic             rvld;
  logic             lo_eq;
  logic             wchg;

  logic [LIM_W-1:0] lim;
  logic             in_range;
  logic             wide_ok;
  logic             err;
  logic [31:0]      old_word;
  logic [31:0]      lo;
  logic [31:0]      hi;
  logic [31:0]      nv;
  logic             writes;
  logic             chg;
  logic             chg_wide;
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic [IDX_W-1:0] idx_p1;

  assign lo       = val_q[31:0];
  assign hi       = val_q[63:32];
  assign idx_p1   = idx_q + IDX_W'(1);
  assign old_word = rvld ? rdata : 32'd0;

  assign lim      = (values_in_use > ENTRIES_LIM) ? ENTRIES_LIM : values_in_use;
  assign in_range = {1'b0, idx_q} < lim;
  assign wide_ok  = ({1'b0, idx_q} + LIM_W'(1)) < lim;

  always_comb begin
    err = 1'b0;
    if (cmd_q == CMD_UNMARK) begin
      err = 1'b0;
    end else if (cmd_q > CMD_LOAD || !in_range) begin
      err = 1'b1;
    end else if (cmd_q == CMD_WIDE && !wide_ok) begin
      err = 1'b1;
    end else if (cmd_q == CMD_HALF && lane_q[1]) begin
      err = 1'b1;
    end
  end

  // New word for the one-word commands.
  always_comb begin
    nv     = old_word;
    writes = 1'b1;
    case (cmd_q)
      CMD_WRITE, CMD_LOAD: nv = lo;
      CMD_CLAMP: nv = lo[31] ? 32'd0 : lo;
      CMD_BYTE: begin
        case (lane_q)
          2'd0:    nv = {old_word[31:8], lo[7:0]};
          2'd1:    nv = {old_word[31:16], lo[7:0], old_word[7:0]};
          2'd2:    nv = {old_word[31:24], lo[7:0], old_word[15:0]};
          default: nv = {lo[7:0], old_word[23:0]};
        endcase
      end
      CMD_HALF: nv = lane_q[0] ? {lo[15:0], old_word[15:0]} : {old_word[31:16], lo[15:0]};
      CMD_SET:   nv = old_word | lo;
      CMD_CLEAR: nv = old_word & ~lo;
      default:   writes = 1'b0;
    endcase
  end

  assign chg      = writes && !err && (nv != old_word);
  assign chg_wide = !lo_eq || (old_word != hi);

  assign stat.is_wide  = (cmd_q == CMD_WIDE) && !err;
  assign stat.out_free = !out_valid || out_ready;

  // Memory port selection.
  always_comb begin
    rd_en = cmd.capture || cmd.wide_lo;
    raddr = cmd.capture ? in_index : idx_p1;
    wr_en = (cmd.fin_single && chg) || cmd.wide_cmp || cmd.fin_wide;
    waddr = cmd.fin_wide ? idx_p1 : idx_q;
    wdata = cmd.fin_wide ? hi : (cmd.wide_cmp ? lo : nv);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= in_command;
      idx_q  <= in_index;
      lane_q <= in_lane;
      val_q  <= in_value;
    end
    if (cmd.wide_lo) begin
      lo_eq <= (old_word == lo);
    end
    if (cmd.wide_cmp) begin
      wchg <= chg_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      values_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      values_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (cmd.fin_single && cmd_q == CMD_UNMARK) begin
      marks <= '0;
    end else if (cmd.fin_single && chg && cmd_q != CMD_LOAD) begin
      marks[idx_q] <= 1'b1;
    end else if (cmd.fin_wide && wchg) begin
      marks[idx_q]  <= 1'b1;
      marks[idx_p1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_single || cmd.fin_wide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_single) begin
      if (cmd_q == CMD_UNMARK) begin
        out_read_value <= in_range ? old_word : 32'd0;
        out_changed    <= 1'b0;
        out_dirty      <= 1'b0;
        out_error      <= 1'b0;
      end else if (err) begin
        out_read_value <= 32'd0;
        out_changed    <= 1'b0;
        out_dirty      <= 1'b0;
        out_error      <= 1'b1;
      end else begin
        out_read_value <= nv;
        out_changed    <= chg;
        out_dirty      <= (chg && cmd_q != CMD_LOAD) || marks[idx_q];
        out_error      <= 1'b0;
      end
    end else if (cmd.fin_wide) begin
      out_read_value <= lo;
      out_changed    <= wchg;
      out_dirty      <= wchg || marks[idx_q];
      out_error      <= 1'b0;
    end
  end

endmodule
